>>> hdl/linear_interp_chunk_resampler_unit_macros.svh
// Assertion macros shared by the resampler modules.
`ifndef LINEAR_INTERP_CHUNK_RESAMPLER_UNIT_MACROS_SVH
`define LINEAR_INTERP_CHUNK_RESAMPLER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LIR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define LIR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/lir_pkg.sv
// Shared constants, codes and types of the chunk resampler.
package lir_pkg;

    localparam int FRAC_BITS      = 12;
    localparam int SECTOR_SAMPLES = 64;
    localparam int CHANNELS_DFLT  = 2;

    localparam int IDX_W   = $clog2(SECTOR_SAMPLES);
    localparam int OFS_W   = IDX_W + FRAC_BITS;
    localparam int ADDR_W  = IDX_W + 1;
    localparam int DEPTH   = 2 * SECTOR_SAMPLES;
    localparam int SMP_W   = 16;
    localparam int CHUNK_W = 16;
    localparam int POS_W   = 18;
    localparam int SIDX_W  = 6;
    localparam int STEP_W  = 19;
    localparam int THR_W   = 18;
    localparam int PADDR_W = 3;
    localparam int APB_W   = 32;
    localparam int T_W     = ((OFS_W + 1 > STEP_W) ? OFS_W + 1 : STEP_W) + 1;

    localparam logic signed [STEP_W-1:0] STEP_RESET = STEP_W'(4096);
    localparam logic [THR_W-1:0]         THR_RESET  = THR_W'(100);

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_SET_POS = 2'd1,
        OP_NEXT    = 2'd2,
        OP_FLUSH   = 2'd3
    } lir_op_t;

    typedef enum logic [1:0] {
        ST_FRAME  = 2'd0,
        ST_SILENT = 2'd1,
        ST_MISS   = 2'd2,
        ST_ACCEPT = 2'd3
    } lir_status_t;

    typedef enum logic {
        REG_STEP   = 1'b0,
        REG_THRESH = 1'b1
    } lir_reg_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [ADDR_W-1:0] rd_addr_a;
        logic [ADDR_W-1:0] rd_addr_b;
    } lir_mem_req_t;

    typedef struct packed {
        lir_status_t        status;
        logic [CHUNK_W-1:0] need;
        logic [FRAC_BITS-1:0] alpha;
    } lir_meta_t;

endpackage

>>> hdl/linear_interp_chunk_resampler_unit.sv
// Stereo linear-interpolation resampler over a two-slot chunk cache (top level).
// A taken beat passes the memory read registers, the multiply and round-and-add stages and the
// output register; throughput one beat a cycle while m_axis_tready does not stall the pipeline,
// set by the position update and the two sample memory read ports. Reset clears slot tags and
// valid bits, position, pipeline; step 4096, threshold 100. The sample memory is not cleared.
module linear_interp_chunk_resampler_unit #(
    parameter int CHANNELS = lir_pkg::CHANNELS_DFLT
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // chunk, sample_index, position, left_in, right_in
    input  logic [71:0]                 s_axis_tdata,
    // op, slot
    input  logic [2:0]                  s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // left_out, right_out, needed_chunk
    output logic [47:0]                 m_axis_tdata,
    // status
    output logic [1:0]                  m_axis_tuser,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lir_pkg::PADDR_W-1:0] paddr,
    input  logic [lir_pkg::APB_W-1:0]   pwdata,
    output logic [lir_pkg::APB_W-1:0]   prdata,
    output logic                        pready
);
    import lir_pkg::*;

    logic                      accept;
    logic [1:0]                op;
    logic                      slot;
    logic [CHUNK_W-1:0]        chunk;
    logic [SIDX_W-1:0]         sample_index;
    logic [POS_W-1:0]          position;
    logic [SMP_W-1:0]          left_in, right_in;
    logic signed [STEP_W-1:0]  step;
    logic [THR_W-1:0]          silence_threshold;
    lir_mem_req_t              mem_req;
    lir_meta_t                 meta;
    logic                      rd_en;
    logic [CHANNELS*SMP_W-1:0] wr_data, rd_a, rd_b;
    logic signed [SMP_W-1:0]   left_out, right_out;
    lir_status_t               status;
    logic [CHUNK_W-1:0]        needed_chunk;

    assign op           = s_axis_tuser[1:0];
    assign slot         = s_axis_tuser[2];
    assign chunk        = s_axis_tdata[15:0];
    assign sample_index = s_axis_tdata[21:16];
    assign position     = s_axis_tdata[39:22];
    assign left_in      = s_axis_tdata[55:40];
    assign right_in     = s_axis_tdata[71:56];
    assign accept       = s_axis_tvalid && s_axis_tready;
    assign wr_data      = (CHANNELS*SMP_W)'({right_in, left_in});

    lir_cfg u_cfg
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .step              (step),
        .silence_threshold (silence_threshold)
    );

    lir_ctrl u_ctrl
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .accept            (accept),
        .op                (op),
        .slot              (slot),
        .chunk             (chunk),
        .sample_index      (sample_index),
        .position          (position),
        .step              (step),
        .silence_threshold (silence_threshold),
        .mem_req           (mem_req),
        .meta              (meta),
        .rd_en             (rd_en)
    );

    lir_cache #(
        .CHANNELS (CHANNELS)
    ) u_cache
    (
        .clk     (clk),
        .mem_req (mem_req),
        .rd_en   (rd_en),
        .wr_data (wr_data),
        .rd_a    (rd_a),
        .rd_b    (rd_b)
    );

    lir_interp #(
        .CHANNELS (CHANNELS)
    ) u_interp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_load      (accept),
        .in_ready     (s_axis_tready),
        .meta_in      (meta),
        .rd_a         (rd_a),
        .rd_b         (rd_b),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .left_out     (left_out),
        .right_out    (right_out),
        .status       (status),
        .needed_chunk (needed_chunk)
    );

    assign m_axis_tdata = {needed_chunk, right_out, left_out};
    assign m_axis_tuser = status;

endmodule

>>> hdl/lir_cfg.sv
// Configuration register file behind the APB-style port.
module lir_cfg
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lir_pkg::PADDR_W-1:0]       paddr,
    input  logic [lir_pkg::APB_W-1:0]         pwdata,
    output logic [lir_pkg::APB_W-1:0]         prdata,
    output logic                              pready,
    output logic signed [lir_pkg::STEP_W-1:0] step,
    output logic [lir_pkg::THR_W-1:0]         silence_threshold
);
    import lir_pkg::*;

    logic signed [STEP_W-1:0] step_reg, step_next;
    logic [THR_W-1:0]         thr_reg, thr_next;
    logic                     wr;
    lir_reg_t                 sel;

    always_comb
    begin
        sel       = lir_reg_t'(paddr[2]);
        wr        = psel && penable && pwrite && pready;
        step_next = step_reg;
        thr_next  = thr_reg;
        prdata    = '0;
        case (sel)
            REG_STEP:
            begin
                prdata = APB_W'(step_reg);
                if (wr)
                begin
                    step_next = signed'(pwdata[STEP_W-1:0]);
                end
            end
            REG_THRESH:
            begin
                prdata = APB_W'(thr_reg);
                if (wr)
                begin
                    thr_next = pwdata[THR_W-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_RESET;
            thr_reg  <= THR_RESET;
        end
        else
        begin
            step_reg <= step_next;
            thr_reg  <= thr_next;
        end
    end

    assign pready            = 1'b1;
    assign step              = step_reg;
    assign silence_threshold = thr_reg;

endmodule

>>> hdl/lir_ctrl.sv
// Position, slot tag and cache lookup control; issues sample memory accesses.
`include "linear_interp_chunk_resampler_unit_macros.svh"

module lir_ctrl
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic [1:0]                        op,
    input  logic                              slot,
    input  logic [lir_pkg::CHUNK_W-1:0]       chunk,
    input  logic [lir_pkg::SIDX_W-1:0]        sample_index,
    input  logic [lir_pkg::POS_W-1:0]         position,
    input  logic signed [lir_pkg::STEP_W-1:0] step,
    input  logic [lir_pkg::THR_W-1:0]         silence_threshold,
    output lir_pkg::lir_mem_req_t             mem_req,
    output lir_pkg::lir_meta_t                meta,
    output logic                              rd_en
);
    import lir_pkg::*;

    logic [CHUNK_W-1:0]   tag_reg [2];
    logic [CHUNK_W-1:0]   tag_next [2];
    logic [1:0]           slot_valid_reg, slot_valid_next;
    logic [CHUNK_W-1:0]   chunk_reg, chunk_next;
    logic [OFS_W-1:0]     offset_reg, offset_next;

    lir_op_t              op_c;
    logic [IDX_W-1:0]     idx, idx2;
    logic [FRAC_BITS-1:0] alpha;
    logic [CHUNK_W-1:0]   next_chunk;
    logic [1:0]           hit_cur, hit_nxt;
    logic                 last, s1, s2, slow;
    logic [STEP_W-1:0]    step_mag;
    logic signed [T_W-1:0] t_sum, t_quo;

    always_comb
    begin
        op_c       = lir_op_t'(op);
        idx        = offset_reg[OFS_W-1:FRAC_BITS];
        alpha      = offset_reg[FRAC_BITS-1:0];
        next_chunk = chunk_reg + CHUNK_W'(1);
        for (int s = 0; s < 2; s++)
        begin
            hit_cur[s] = slot_valid_reg[s] && (tag_reg[s] == chunk_reg);
            hit_nxt[s] = slot_valid_reg[s] && (tag_reg[s] == next_chunk);
        end
        last     = (idx == IDX_W'(SECTOR_SAMPLES - 1));
        idx2     = last ? '0 : idx + IDX_W'(1);
        s1       = !hit_cur[0];
        s2       = last ? !hit_nxt[0] : s1;
        step_mag = step[STEP_W-1] ? -step : step;
        slow     = step_mag < STEP_W'(silence_threshold);

        meta.status = ST_ACCEPT;
        meta.need   = '0;
        meta.alpha  = alpha;
        if (op_c == OP_NEXT)
        begin
            if (slow)
            begin
                meta.status = ST_SILENT;
            end
            else if (hit_cur == 2'b00)
            begin
                meta.status = ST_MISS;
                meta.need   = chunk_reg;
            end
            else if (last && (hit_nxt == 2'b00))
            begin
                meta.status = ST_MISS;
                meta.need   = next_chunk;
            end
            else
            begin
                meta.status = ST_FRAME;
            end
        end

        t_sum = T_W'(signed'({1'b0, offset_reg})) + T_W'(step);
        t_quo = t_sum >>> OFS_W;

        tag_next        = tag_reg;
        slot_valid_next = slot_valid_reg;
        chunk_next      = chunk_reg;
        offset_next     = offset_reg;
        if (accept)
        begin
            case (op_c)
                OP_LOAD:
                begin
                    tag_next[slot]        = chunk;
                    slot_valid_next[slot] = 1'b1;
                end
                OP_SET_POS:
                begin
                    chunk_next  = chunk + CHUNK_W'(position >> OFS_W);
                    offset_next = OFS_W'(position);
                end
                OP_NEXT:
                begin
                    if (meta.status == ST_FRAME)
                    begin
                        offset_next = t_sum[OFS_W-1:0];
                        chunk_next  = chunk_reg + CHUNK_W'(t_quo);
                    end
                end
                OP_FLUSH:
                begin
                    slot_valid_next = '0;
                end
                default:
                begin
                    slot_valid_next = slot_valid_reg;
                end
            endcase
        end

        mem_req.wr_en     = accept && (op_c == OP_LOAD)
                            && (32'(sample_index) < SECTOR_SAMPLES);
        mem_req.wr_addr   = {slot, IDX_W'(sample_index)};
        mem_req.rd_addr_a = {s1, idx};
        mem_req.rd_addr_b = {s2, idx2};
        rd_en             = accept && (meta.status == ST_FRAME);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg[0]     <= '0;
            tag_reg[1]     <= '0;
            slot_valid_reg <= '0;
            chunk_reg      <= '0;
            offset_reg     <= '0;
        end
        else
        begin
            tag_reg        <= tag_next;
            slot_valid_reg <= slot_valid_next;
            chunk_reg      <= chunk_next;
            offset_reg     <= offset_next;
        end
    end

    `LIR_ASSERT_NXT(a_no_advance_unless_frame, accept && (op_c == OP_NEXT) && (meta.status != ST_FRAME), $stable(chunk_reg) && $stable(offset_reg), "position moved on a silent or missed frame")
    `LIR_ASSERT_NXT(a_flush_clears_slots, accept && (op_c == OP_FLUSH), slot_valid_reg == 2'b00, "flush left a slot valid")
    `LIR_ASSERT_NXT(a_load_marks_slot, accept && (op_c == OP_LOAD), slot_valid_reg[$past(slot)], "load did not mark its slot valid")

endmodule

>>> hdl/lir_cache.sv
// Two-slot sample cache: one write port, two registered read ports.
module lir_cache #(
    parameter int CHANNELS = lir_pkg::CHANNELS_DFLT
)
(
    input  logic                                clk,
    input  lir_pkg::lir_mem_req_t               mem_req,
    input  logic                                rd_en,
    input  logic [CHANNELS*lir_pkg::SMP_W-1:0]  wr_data,
    output logic [CHANNELS*lir_pkg::SMP_W-1:0]  rd_a,
    output logic [CHANNELS*lir_pkg::SMP_W-1:0]  rd_b
);
    import lir_pkg::*;

    localparam int WORD_W = CHANNELS * SMP_W;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_a_reg, rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.wr_en)
        begin
            mem[mem_req.wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_a_reg <= mem[mem_req.rd_addr_a];
            rd_b_reg <= mem[mem_req.rd_addr_b];
        end
    end

    assign rd_a = rd_a_reg;
    assign rd_b = rd_b_reg;

endmodule

>>> hdl/lir_interp.sv
// Interpolation pipeline: multiply stage, round-and-add stage, output register.
`include "linear_interp_chunk_resampler_unit_macros.svh"

module lir_interp #(
    parameter int CHANNELS = lir_pkg::CHANNELS_DFLT
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_load,
    output logic                               in_ready,
    input  lir_pkg::lir_meta_t                 meta_in,
    input  logic [CHANNELS*lir_pkg::SMP_W-1:0] rd_a,
    input  logic [CHANNELS*lir_pkg::SMP_W-1:0] rd_b,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [lir_pkg::SMP_W-1:0]   left_out,
    output logic signed [lir_pkg::SMP_W-1:0]   right_out,
    output lir_pkg::lir_status_t               status,
    output logic [lir_pkg::CHUNK_W-1:0]        needed_chunk
);
    import lir_pkg::*;

    localparam int PROD_W = SMP_W + FRAC_BITS + 2;
    localparam logic signed [PROD_W-1:0] RND = PROD_W'((1 << FRAC_BITS) - 1);

    logic v1_reg, v1_next, v2_reg, v2_next, vo_reg, vo_next;
    logic rdy1, rdy2, rdyo;

    lir_meta_t meta1_reg, meta2_reg;

    logic signed [SMP_W-1:0]  smp_a [2];
    logic signed [SMP_W-1:0]  smp_b [2];
    logic signed [SMP_W:0]    diff [2];
    logic signed [FRAC_BITS:0] alpha_s;
    logic signed [PROD_W-1:0] prod_next [2];
    logic signed [PROD_W-1:0] prod_reg [2];
    logic signed [SMP_W-1:0]  base_next [2];
    logic signed [SMP_W-1:0]  base_reg [2];
    logic signed [PROD_W-1:0] adj [2];
    logic signed [PROD_W-1:0] quo [2];
    logic signed [SMP_W-1:0]  res [2];

    logic signed [SMP_W-1:0]  left_reg, left_next, right_reg, right_next;
    lir_status_t              status_reg;
    logic [CHUNK_W-1:0]       need_reg;

    always_comb
    begin
        rdyo    = !vo_reg || out_ready;
        rdy2    = !v2_reg || rdyo;
        rdy1    = !v1_reg || rdy2;
        v1_next = rdy1 ? in_load : v1_reg;
        v2_next = rdy2 ? v1_reg : v2_reg;
        vo_next = rdyo ? v2_reg : vo_reg;
    end

    always_comb
    begin
        smp_a[0] = rd_a[SMP_W-1:0];
        smp_a[1] = rd_a[CHANNELS*SMP_W-1 -: SMP_W];
        smp_b[0] = rd_b[SMP_W-1:0];
        smp_b[1] = rd_b[CHANNELS*SMP_W-1 -: SMP_W];
        alpha_s  = signed'({1'b0, meta1_reg.alpha});
        for (int l = 0; l < 2; l++)
        begin
            diff[l]      = (SMP_W+1)'(smp_b[l]) - (SMP_W+1)'(smp_a[l]);
            prod_next[l] = PROD_W'(diff[l]) * PROD_W'(alpha_s);
            base_next[l] = smp_a[l];
            // truncate toward zero
            adj[l]       = prod_reg[l][PROD_W-1] ? prod_reg[l] + RND : prod_reg[l];
            quo[l]       = adj[l] >>> FRAC_BITS;
            res[l]       = base_reg[l] + SMP_W'(quo[l]);
        end
        left_next  = (meta2_reg.status == ST_FRAME) ? res[0] : '0;
        right_next = (meta2_reg.status == ST_FRAME) ? res[1] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            vo_reg <= vo_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_load)
        begin
            meta1_reg <= meta_in;
        end
        if (rdy2 && v1_reg)
        begin
            meta2_reg <= meta1_reg;
            prod_reg  <= prod_next;
            base_reg  <= base_next;
        end
        if (rdyo && v2_reg)
        begin
            left_reg   <= left_next;
            right_reg  <= right_next;
            status_reg <= meta2_reg.status;
            need_reg   <= meta2_reg.need;
        end
    end

    assign in_ready     = rdy1;
    assign out_valid    = vo_reg;
    assign left_out     = left_reg;
    assign right_out    = right_reg;
    assign status       = status_reg;
    assign needed_chunk = need_reg;

    `LIR_ASSERT_IMP(a_quiet_unless_frame, vo_reg && (status_reg != ST_FRAME), (left_reg == '0) && (right_reg == '0), "samples not zero on a non-frame beat")
    `LIR_ASSERT_IMP(a_need_only_on_miss, vo_reg && (status_reg != ST_MISS), need_reg == '0, "needed chunk set without a miss")
    `LIR_ASSERT_IMP(a_stage2_from_stage1, $rose(v2_reg), $past(v1_reg), "second stage filled from an empty first stage")

endmodule
